// ----- hw/rtl/fqid_pkg.sv -----
// Shared types and constants for the identifier-allocating queue.
// Used by fqid_front, fqid_back and the top level fifo_queue_with_id_alloc.
package fqid_pkg;

   // Operation codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_ENQ  = 3'd0,
      OP_DEQ  = 3'd1,
      OP_RD   = 3'd2,
      OP_FIND = 3'd3,
      OP_REM  = 3'd4,
      OP_CLR  = 3'd5,
      OP_NOP  = 3'd6
   } op_type;

   // Response status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Entries in the command queue between the front and back parts.
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_READ,
      S_SHIFT,
      S_FINISH
   } state_type;

   // One classified request item.
   typedef struct packed {
      op_type      operation;
      logic [15:0] handle_in;
      logic [3:0]  position;
      logic [15:0] key;
   } cmd_type;

endpackage

// ----- hw/rtl/fqid_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module fqid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fqid_front.sv -----
// Front part: accepts request items, classifies the operation code and
// holds them in a short command queue. Depends on fqid_pkg.
module fqid_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic [15:0]       req_handle_in,
   input  logic [3:0]        req_position,
   input  logic [15:0]       req_key,
   output logic              cmd_valid,
   output fqid_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import fqid_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int FILL_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            q_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               push;
   logic               pop;
   cmd_type            new_cmd;

   // Unused operation codes become an explicit no-operation.
   always_comb begin
      new_cmd.handle_in = req_handle_in;
      new_cmd.position  = req_position;
      new_cmd.key       = req_key;
      if (req_operation <= OP_CLR) begin
         new_cmd.operation = op_type'(req_operation);
      end else begin
         new_cmd.operation = OP_NOP;
      end
   end

   assign req_stall = (fill_ff == FILL_W'(CMDQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hw/rtl/fqid_back.sv -----
// Back part: a sequencer that carries out one command at a time against the
// entry memory and drives the response register. Depends on fqid_pkg, fqid_ram.
module fqid_back #(
   parameter int DEPTH       = 16,
   parameter int ID_BITS     = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  fqid_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [15:0]       rsp_id_out,
   output logic [15:0]       rsp_handle_out,
   output logic [4:0]        rsp_fill_count
);
   import fqid_pkg::*;

   localparam int     AW      = $clog2(DEPTH);
   localparam int     CW      = $clog2(DEPTH + 1);
   localparam int     WW      = ID_BITS + HANDLE_BITS;
   localparam int     DW      = ID_BITS + 1;
   localparam int     CMPW    = (ID_BITS > 16) ? ID_BITS : 16;
   localparam int     PW      = (CW > 4) ? CW : 4;
   localparam longint MAXID_L = (longint'(1) << ID_BITS) - 1;
   // Highest candidate offset worth checking; beyond it the sequence repeats
   // or a free identifier is certain to have been found.
   localparam int     LIM     = int'((longint'(DEPTH) < MAXID_L) ? longint'(DEPTH)
                                                               : MAXID_L - 1);
   localparam int     KW      = $clog2(LIM + 1);
   localparam logic [ID_BITS-1:0] MAXID = '1;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [ID_BITS-1:0]      nfid_ff, nfid_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    dv_ff, dv_in;
   logic [CW-1:0]           didx_ff, didx_in;
   logic [LIM:0]            bmap_ff, bmap_in;
   logic [KW-1:0]           kofs_ff, kofs_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [ID_BITS-1:0]      res_id_ff, res_id_in;
   logic [HANDLE_BITS-1:0]  res_handle_ff, res_handle_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [15:0]             rsp_id_ff, rsp_id_in;
   logic [15:0]             rsp_handle_ff, rsp_handle_in;
   logic [4:0]              rsp_fill_ff, rsp_fill_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [WW-1:0]           ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [WW-1:0]           ram_rdata;

   logic [ID_BITS-1:0]      rd_id;
   logic [HANDLE_BITS-1:0]  rd_handle;
   logic [DW-1:0]           id_gap;
   logic                    in_range;
   logic [DW-1:0]           sum;
   logic [ID_BITS-1:0]      cand;
   logic [ID_BITS-1:0]      cand_next;
   logic                    key_hit;
   logic                    out_free;
   logic [CW-1:0]           didx_m1;
   logic                    stream_done;

   fqid_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_id     = ram_rdata[WW-1:HANDLE_BITS];
   assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
   assign key_hit   = (CMPW'(rd_id) == CMPW'(cmd_ff.key));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign didx_m1   = didx_ff - CW'(1);
   assign stream_done = !dv_ff && (idx_ff >= cnt_ff);

   // Distance of a queued identifier from the allocation counter, measured
   // along the wrapping sequence 1..MAXID.
   always_comb begin
      if (rd_id >= nfid_ff) begin
         id_gap = DW'(rd_id) - DW'(nfid_ff);
      end else begin
         id_gap = DW'(rd_id) + DW'(MAXID) - DW'(nfid_ff);
      end
      in_range = (id_gap <= DW'(LIM));
   end

   always_comb begin
      sum = DW'(nfid_ff) + DW'(kofs_ff);
      if (sum > DW'(MAXID)) begin
         cand = ID_BITS'(sum - DW'(MAXID));
      end else begin
         cand = ID_BITS'(sum);
      end
      cand_next = (cand == MAXID) ? ID_BITS'(1) : cand + ID_BITS'(1);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      nfid_in       = nfid_ff;
      idx_in        = idx_ff;
      dv_in         = 1'b0;
      didx_in       = didx_ff;
      bmap_in       = bmap_ff;
      kofs_in       = kofs_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_fill_in   = rsp_fill_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = didx_m1[AW-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd.operation == OP_RD) begin
               ram_raddr = AW'(cmd.position);
            end else begin
               ram_raddr = '0;
            end
            if (cmd_valid) begin
               cmd_in        = cmd;
               res_status_in = ST_OK;
               res_id_in     = '0;
               res_handle_in = '0;
               idx_in        = '0;
               bmap_in       = '0;
               kofs_in       = '0;
               case (cmd.operation)
                  OP_ENQ: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_DEQ: begin
                     if (cnt_ff == '0) begin
                        res_status_in = ST_MISS;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_RD: begin
                     if (PW'(cmd.position) >= PW'(cnt_ff)) begin
                        res_status_in = ST_MISS;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_FIND, OP_REM: begin
                     if (cnt_ff == '0) begin
                        res_status_in = ST_MISS;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_CLR: begin
                     cnt_in   = '0;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // Streams the entries through the read port, one per cycle; the
         // data of the previous address is checked while the next is read.
         S_SCAN: begin
            if (stream_done) begin
               if (cmd_ff.operation == OP_ENQ) begin
                  state_in = S_ALLOC;
               end else begin
                  res_status_in = ST_MISS;
                  state_in      = S_FINISH;
               end
            end else begin
               if (idx_ff < cnt_ff) begin
                  dv_in   = 1'b1;
                  didx_in = idx_ff;
                  idx_in  = idx_ff + CW'(1);
               end
               if (dv_ff) begin
                  if (cmd_ff.operation == OP_ENQ) begin
                     if (in_range) begin
                        bmap_in[id_gap[KW-1:0]] = 1'b1;
                     end
                  end else if (key_hit) begin
                     res_id_in     = rd_id;
                     res_handle_in = rd_handle;
                     dv_in         = 1'b0;
                     if (cmd_ff.operation == OP_REM) begin
                        idx_in   = didx_ff + CW'(1);
                        state_in = S_SHIFT;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               end
            end
         end

         // Walks the offsets from the counter until one is not taken; if all up to LIM are taken, reports full.
         S_ALLOC: begin
            if (!bmap_ff[kofs_ff]) begin
               ram_we        = 1'b1;
               ram_waddr     = cnt_ff[AW-1:0];
               ram_wdata     = {cand, HANDLE_BITS'(cmd_ff.handle_in)};
               cnt_in        = cnt_ff + CW'(1);
               nfid_in       = cand_next;
               res_id_in     = cand;
               res_handle_in = HANDLE_BITS'(cmd_ff.handle_in);
               state_in      = S_FINISH;
            end else if (kofs_ff == KW'(LIM)) begin
               res_status_in = ST_FULL;
               state_in      = S_FINISH;
            end else begin
               kofs_in = kofs_ff + KW'(1);
            end
         end

         S_READ: begin
            res_id_in     = rd_id;
            res_handle_in = rd_handle;
            if (cmd_ff.operation == OP_DEQ) begin
               idx_in   = CW'(1);
               state_in = S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end

         // Moves every entry after the removed one down by one place.
         S_SHIFT: begin
            if (stream_done) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_FINISH;
            end else begin
               if (idx_ff < cnt_ff) begin
                  dv_in   = 1'b1;
                  didx_in = idx_ff;
                  idx_in  = idx_ff + CW'(1);
               end
               if (dv_ff) begin
                  ram_we = 1'b1;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = 16'(res_id_ff);
               rsp_handle_in = 16'(res_handle_ff);
               rsp_fill_in   = 5'(cnt_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         nfid_ff      <= ID_BITS'(1);
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nfid_ff      <= nfid_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      didx_ff       <= didx_in;
      bmap_ff       <= bmap_in;
      kofs_ff       <= kofs_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_id_out     = rsp_id_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

// ----- hw/rtl/fifo_queue_with_id_alloc.sv -----
// Time from request to response: clear, unused codes and the empty, full and out-of-range
// cases go straight to the response; read fetches one entry; dequeue, find, remove and
// enqueue depend on the fill level, enqueue also on the free offset found. The time is set
// by the entry scan through the single read port; the next item can be taken in the cycle
// after a response is loaded. Reset: empty queue, next identifier 1; entry memory left
// undefined.
module fifo_queue_with_id_alloc #(
   parameter int DEPTH       = 16,
   parameter int ID_BITS     = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_handle_in,
   input  logic [3:0]  req_position,
   input  logic [15:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_id_out,
   output logic [15:0] rsp_handle_out,
   output logic [4:0]  rsp_fill_count
);
   import fqid_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   fqid_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_handle_in (req_handle_in),
      .req_position  (req_position),
      .req_key       (req_key),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   fqid_back #(
      .DEPTH       (DEPTH),
      .ID_BITS     (ID_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_id_out     (rsp_id_out),
      .rsp_handle_out (rsp_handle_out),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule
